[rtl/sdisp_pkg.sv]
// Shared types and constants for the server dispatcher.
package sdisp_pkg;

	// Field widths fixed by the stream format
	localparam int JOB_BITS   = 16;
	localparam int SIDX_BITS  = 3;
	localparam int DEST_BITS  = 3;
	localparam int WAIT_BITS  = 7;
	localparam int LOAD_BITS  = 8;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_TUSER_W = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

	// Command codes
	localparam logic CMD_ARRIVAL = 1'b0;
	localparam logic CMD_DONE    = 1'b1;

	// Policy codes
	localparam logic POL_CENTRAL  = 1'b0;
	localparam logic POL_SHORTEST = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'b1;

	// Reset values of the registers
	localparam logic [CFG_DATA_W-1:0] ACTIVE_RESET = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	// Control strobes from the sequencer to the datapath
	typedef struct packed {
		logic in_ready;
		logic search_en;
		logic finish_en;
	} ctrl_t;

endpackage

[rtl/sdisp_min_tree.sv]
// Compare tree that finds the first active server with the smallest load.
module sdisp_min_tree #(
	parameter int NUM_SERVERS = 8
) (
	input  logic [sdisp_pkg::LOAD_BITS-1:0]  loads [NUM_SERVERS],
	input  logic [sdisp_pkg::CFG_DATA_W-1:0] active,
	output logic [((NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1)-1:0] best_idx,
	output logic                             best_idle
);
	import sdisp_pkg::*;

	localparam int IDX_W  = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
	localparam int LEAVES = 1 << IDX_W;
	localparam int NODES  = 2 * LEAVES - 1;

	logic                 node_vld [NODES];
	logic [LOAD_BITS-1:0] node_key [NODES];
	logic [IDX_W-1:0]     node_idx [NODES];

	// Leaves: server 0 is always in use, a zero active count acts as one
	for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
		if (k < NUM_SERVERS) begin : g_real
			assign node_vld[LEAVES-1+k] = (k == 0) || (k < int'(active));
			assign node_key[LEAVES-1+k] = loads[k];
		end else begin : g_pad
			assign node_vld[LEAVES-1+k] = 1'b0;
			assign node_key[LEAVES-1+k] = '0;
		end
		assign node_idx[LEAVES-1+k] = IDX_W'(k);
	end

	// Inner nodes: ties go to the left, so the lowest index wins
	for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
		logic take_l;
		assign take_l = node_vld[2*n+1] &&
			(!node_vld[2*n+2] || (node_key[2*n+1] <= node_key[2*n+2]));
		assign node_vld[n] = node_vld[2*n+1] || node_vld[2*n+2];
		assign node_key[n] = take_l ? node_key[2*n+1] : node_key[2*n+2];
		assign node_idx[n] = take_l ? node_idx[2*n+1] : node_idx[2*n+2];
	end

	// The minimum is also the first idle server when it is zero
	assign best_idx  = node_idx[0];
	assign best_idle = (node_key[0] == '0);

endmodule

[rtl/server_dispatcher.sv]
// Top level of the server dispatcher: sequencer, load counters and wait FIFO.
//
// Channel   Dir  Signals                          Payload
// s_*       in   s_tvalid s_tready s_tdata s_tuser job arrival or completion beat
// m_*       out  m_tvalid m_tready m_tdata m_tuser one result beat per input beat
// cfg_*     in   cfg_valid cfg_ready cfg_index cfg_data register write
//
// Each item passes through the accept edge, the search state (completion
// decrement, compare tree over the load counters, FIFO head read) and the
// finish state (load increment, FIFO push/pop, result register).
// The registered FIFO memory read sets the search/finish split.
// A full result register holds the finish cycle until m_tready; the next
// item is accepted while the previous result waits.
// Reset clears loads, pointers and control at once; FIFO memory is not cleared.
module server_dispatcher #(
	parameter int NUM_SERVERS = 8,
	parameter int FIFO_DEPTH  = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [15:0] job_id, [18:16] server_index, [23:19] zero
	input  logic [sdisp_pkg::IN_TDATA_W-1:0]    s_tdata,
	// [0] command
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [2:0] dest_server, [18:3] sent_job_id, [25:19] waiting_count, [31:26] zero
	output logic [sdisp_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// [0] dispatched, [1] dropped
	output logic [sdisp_pkg::OUT_TUSER_W-1:0]   m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sdisp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sdisp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import sdisp_pkg::*;

	localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic                  policy_q;
	logic [CFG_DATA_W-1:0] active_q;

	logic                 cmd_q;
	logic [JOB_BITS-1:0]  job_q;
	logic [SIDX_BITS-1:0] sidx_q;

	logic [LOAD_BITS-1:0] load_q [NUM_SERVERS];
	logic [LOAD_BITS-1:0] eff    [NUM_SERVERS];

	logic [IDX_W-1:0] tree_idx;
	logic             tree_idle;
	logic [IDX_W-1:0] best_idx_s2;
	logic             best_idle_s2;

	logic [JOB_BITS-1:0] fifo_mem [FIFO_DEPTH];
	logic [JOB_BITS-1:0] head_data_s2;
	logic [PTR_W-1:0]    head_q, tail_q;
	logic [CNT_W-1:0]    count_q, count_d;

	logic                fin_go;
	logic                sent, drop, push, pop;
	logic [JOB_BITS-1:0] sent_id;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_CENTRAL;
			active_q <= ACTIVE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POLICY: policy_q <= cfg_data[0];
				REG_ACTIVE: active_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_SEARCH;
			ST_SEARCH: state_d = ST_FINISH;
			ST_FINISH: if (!m_tvalid || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer: strobes
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE:   ctrl.in_ready  = 1'b1;
			ST_SEARCH: ctrl.search_en = 1'b1;
			ST_FINISH: ctrl.finish_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign s_tready = ctrl.in_ready;
	assign fin_go   = ctrl.finish_en && (!m_tvalid || m_tready);

	// Input beat capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q  <= s_tuser;
			job_q  <= s_tdata[JOB_BITS-1:0];
			sidx_q <= s_tdata[JOB_BITS +: SIDX_BITS];
		end
	end

	// Loads after a completion's decrement, saturating at zero
	always_comb begin
		for (int k = 0; k < NUM_SERVERS; k++) begin
			if (cmd_q == CMD_DONE && int'(sidx_q) == k && load_q[k] != '0)
				eff[k] = load_q[k] - 1'b1;
			else
				eff[k] = load_q[k];
		end
	end

	sdisp_min_tree #(
		.NUM_SERVERS(NUM_SERVERS)
	) u_tree (
		.loads    (eff),
		.active   (active_q),
		.best_idx (tree_idx),
		.best_idle(tree_idle)
	);

	always_ff @(posedge clk) begin
		if (ctrl.search_en) begin
			best_idx_s2  <= tree_idx;
			best_idle_s2 <= tree_idle;
		end
	end

	// Load counters: decrement in search, saturating increment in finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SERVERS; k++) load_q[k] <= '0;
		end else if (ctrl.search_en) begin
			for (int k = 0; k < NUM_SERVERS; k++) load_q[k] <= eff[k];
		end else if (fin_go && sent) begin
			for (int k = 0; k < NUM_SERVERS; k++)
				if (best_idx_s2 == IDX_W'(k) && load_q[k] != LOAD_MAX)
					load_q[k] <= load_q[k] + 1'b1;
		end
	end

	// Dispatch decision
	always_comb begin
		sent    = 1'b0;
		drop    = 1'b0;
		push    = 1'b0;
		pop     = 1'b0;
		sent_id = job_q;
		if (cmd_q == CMD_DONE) begin
			if (policy_q == POL_CENTRAL && count_q != '0 && best_idle_s2) begin
				sent    = 1'b1;
				pop     = 1'b1;
				sent_id = head_data_s2;
			end
		end else if (policy_q == POL_CENTRAL) begin
			if (count_q == '0 && best_idle_s2)
				sent = 1'b1;
			else if (count_q == CNT_W'(FIFO_DEPTH))
				drop = 1'b1;
			else
				push = 1'b1;
		end else begin
			sent = 1'b1;
		end
	end

	always_comb begin
		count_d = count_q;
		if (push)     count_d = count_q + 1'b1;
		else if (pop) count_d = count_q - 1'b1;
	end

	// Wait FIFO memory: push in finish, head read in search
	always_ff @(posedge clk) begin
		if (fin_go && push) fifo_mem[tail_q] <= job_q;
		if (ctrl.search_en) head_data_s2 <= fifo_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (fin_go) begin
			count_q <= count_d;
			if (push)
				tail_q <= (tail_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			if (pop)
				head_q <= (head_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)          m_tvalid <= 1'b0;
		else if (fin_go)      m_tvalid <= 1'b1;
		else if (m_tready)    m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			m_tuser <= {drop, sent};
			m_tdata <= {
				(OUT_TDATA_W - DEST_BITS - JOB_BITS - WAIT_BITS)'(0),
				WAIT_BITS'(count_d),
				sent ? sent_id : {JOB_BITS{1'b0}},
				sent ? DEST_BITS'(best_idx_s2) : {DEST_BITS{1'b0}}
			};
		end
	end

endmodule

[rtl/sdisp_checker.sv]
// Port-level checks for the server dispatcher, bound to the top level.
module sdisp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [sdisp_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [sdisp_pkg::OUT_TUSER_W-1:0] m_tuser
);
	import sdisp_pkg::*;

	// A result beat holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat withdrawn before it was taken");

	// An item is never dispatched and dropped at once
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("result both dispatched and dropped");

	// No dispatch means zero destination and job id
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[DEST_BITS+JOB_BITS-1:0] == '0)
		else $error("idle result carries a destination or job id");

	// The block works on one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

endmodule

bind server_dispatcher sdisp_checker u_sdisp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

[sim/tb_server_dispatcher.sv]
// Self-checking testbench for the server dispatcher: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb_server_dispatcher;
	import sdisp_pkg::*;

	localparam int N_SERVERS   = 8;
	localparam int WAIT_DEPTH  = 64;
	localparam int PTR_BITS    = $clog2(WAIT_DEPTH);
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 20;
	localparam int N_PHASES    = 9;

	// Random phases: policy, active count as written, length, share of arrivals
	localparam logic PHASE_POL [N_PHASES] = '{POL_CENTRAL, POL_CENTRAL, POL_CENTRAL,
		POL_CENTRAL, POL_SHORTEST, POL_SHORTEST, POL_SHORTEST, POL_CENTRAL, POL_CENTRAL};
	localparam int PHASE_ACT [N_PHASES] = '{8, 2, 3, 0, 8, 1, 15, 5, 8};
	localparam int PHASE_LEN [N_PHASES] = '{250, 200, 200, 150, 200, 300, 150, 200, 150};
	localparam int PHASE_ARR [N_PHASES] = '{50, 70, 30, 60, 60, 95, 40, 25, 50};

	// One result beat, unpacked from tdata/tuser
	typedef struct packed {
		logic                 disp;
		logic [DEST_BITS-1:0] dest;
		logic [JOB_BITS-1:0]  id;
		logic                 drop;
		logic [WAIT_BITS-1:0] waiting;
	} dispatch_t;

	typedef enum {ROW_BEAT, ROW_CFG} row_kind_t;
	typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_pattern_t;

	typedef struct {
		row_kind_t               kind;
		logic                    cmd;
		logic [JOB_BITS-1:0]     job;
		logic [SIDX_BITS-1:0]    sidx;
		logic [CFG_IDX_W-1:0]    reg_idx;
		logic [CFG_DATA_W-1:0]   reg_val;
		bit                      typed;
		dispatch_t               want;
	} step_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata;
	logic                    s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic [OUT_TUSER_W-1:0]  m_tuser;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	// Predictor state
	logic [LOAD_BITS-1:0]    srv_load [N_SERVERS];
	logic [JOB_BITS-1:0]     wait_jobs [WAIT_DEPTH];
	logic [PTR_BITS-1:0]     wait_head;
	logic [PTR_BITS-1:0]     wait_tail;
	logic [WAIT_BITS-1:0]    wait_count;
	logic                    cur_policy;
	logic [CFG_DATA_W-1:0]   cur_active;

	dispatch_t               pending_dispatch [$];
	step_row_t               directed_rows [$];
	int                      mismatch_count = 0;
	int                      results_seen = 0;
	int                      burst_left = 0;
	int                      stall_cycles = 0;
	bit                      long_hold_req = 1'b0;

	server_dispatcher #(
		.NUM_SERVERS(N_SERVERS),
		.FIFO_DEPTH (WAIT_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Active count as the block uses it: 0 acts as 1, above the built count saturates
	function automatic int servers_used();
		if (cur_active == '0)
			return 1;
		if (cur_active > N_SERVERS)
			return N_SERVERS;
		return int'(cur_active);
	endfunction

	function automatic int first_idle(input int n);
		int i;
		for (i = 0; i < n; i++)
			if (srv_load[i] == '0)
				return i;
		return -1;
	endfunction

	// Dispatch decision for one accepted beat; advances the predictor state
	function automatic dispatch_t next_dispatch(input logic cmd, input logic [JOB_BITS-1:0] job,
			input logic [SIDX_BITS-1:0] sidx);
		dispatch_t r;
		int n;
		int idle;
		int best;
		int i;
		r = '0;
		n = servers_used();
		if (cmd == CMD_DONE) begin
			if (srv_load[sidx] != '0)
				srv_load[sidx] = srv_load[sidx] - 1'b1;
			// Freed server takes the oldest waiting job
			if (cur_policy == POL_CENTRAL && wait_count != '0) begin
				idle = first_idle(n);
				if (idle >= 0) begin
					r.disp = 1'b1;
					r.dest = DEST_BITS'(idle);
					r.id = wait_jobs[wait_head];
					wait_head = wait_head + 1'b1;
					wait_count = wait_count - 1'b1;
				end
			end
		end else if (cur_policy == POL_CENTRAL) begin
			// Waiting jobs keep their order: no bypass while the queue is not empty
			idle = (wait_count != '0) ? -1 : first_idle(n);
			if (idle >= 0) begin
				r.disp = 1'b1;
				r.dest = DEST_BITS'(idle);
				r.id = job;
			end else if (wait_count == WAIT_DEPTH) begin
				r.drop = 1'b1;
			end else begin
				wait_jobs[wait_tail] = job;
				wait_tail = wait_tail + 1'b1;
				wait_count = wait_count + 1'b1;
			end
		end else begin
			best = 0;
			for (i = 1; i < n; i++)
				if (srv_load[i] < srv_load[best])
					best = i;
			r.disp = 1'b1;
			r.dest = DEST_BITS'(best);
			r.id = job;
		end
		if (r.disp && srv_load[r.dest] != LOAD_MAX)
			srv_load[r.dest] = srv_load[r.dest] + 1'b1;
		r.waiting = wait_count;
		return r;
	endfunction

	function automatic void add_beat_row(input logic cmd, input logic [JOB_BITS-1:0] job,
			input logic [SIDX_BITS-1:0] sidx, input bit typed, input dispatch_t want);
		step_row_t row;
		row = '{kind: ROW_BEAT, cmd: cmd, job: job, sidx: sidx, reg_idx: '0, reg_val: '0,
			typed: typed, want: want};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		step_row_t row;
		row = '{kind: ROW_CFG, cmd: CMD_ARRIVAL, job: '0, sidx: '0, reg_idx: idx, reg_val: val,
			typed: 1'b0, want: '0};
		directed_rows.push_back(row);
	endfunction

	task automatic flag_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		$display("ERROR result %0d: %s expected 0x%0h, got 0x%0h", results_seen, what, want, got);
		mismatch_count++;
	endtask

	// Stop offering and wait until every expected beat has come back
	task automatic settle_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_dispatch.size() != 0)
			@(posedge clk);
	endtask

	// Register write, only with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_POLICY)
			cur_policy = val[0];
		else
			cur_active = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One input beat, sent in bursts with random gaps between them
	task automatic send_beat(input logic cmd, input logic [JOB_BITS-1:0] job,
			input logic [SIDX_BITS-1:0] sidx, input bit typed, input dispatch_t want);
		int gap;
		dispatch_t pred;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {{(IN_TDATA_W - JOB_BITS - SIDX_BITS){1'b0}}, sidx, job};
		do @(posedge clk); while (!s_tready);
		pred = next_dispatch(cmd, job, sidx);
		pending_dispatch.push_back(typed ? want : pred);
	endtask

	// Result side: stall patterns, plus one long hold-off on request
	initial begin
		rx_pattern_t pattern;
		int span;
		int k;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end
			pattern = rx_pattern_t'($urandom_range(0, 3));
			span = $urandom_range(16, 96);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				case (pattern)
					RX_OPEN: m_tready <= 1'b1;
					RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
					RX_PERIODIC: m_tready <= (k % 3 != 2);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Scoreboard: compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_results
		dispatch_t want;
		dispatch_t got;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got.dest = m_tdata[DEST_BITS-1:0];
			got.id = m_tdata[DEST_BITS +: JOB_BITS];
			got.waiting = m_tdata[DEST_BITS + JOB_BITS +: WAIT_BITS];
			got.disp = m_tuser[0];
			got.drop = m_tuser[1];
			if (pending_dispatch.size() == 0) begin
				flag_mismatch("unexpected beat, tdata", 0, m_tdata);
			end else begin
				want = pending_dispatch.pop_front();
				if (got.disp !== want.disp)
					flag_mismatch("dispatched", want.disp, got.disp);
				if (got.dest !== want.dest)
					flag_mismatch("dest_server", want.dest, got.dest);
				if (got.id !== want.id)
					flag_mismatch("sent_job_id", want.id, got.id);
				if (got.drop !== want.drop)
					flag_mismatch("dropped", want.drop, got.drop);
				if (got.waiting !== want.waiting)
					flag_mismatch("waiting_count", want.waiting, got.waiting);
			end
		end
	end

	// Watchdog: too long without any beat on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Main sequence
	initial begin
		int p;
		int k;
		int n;
		logic cmd;
		logic [JOB_BITS-1:0] job;
		logic [SIDX_BITS-1:0] sidx;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_ARRIVAL;
		cfg_valid = 1'b0;
		cfg_index = REG_POLICY;
		cfg_data = '0;
		foreach (srv_load[i])
			srv_load[i] = '0;
		wait_head = '0;
		wait_tail = '0;
		wait_count = '0;
		cur_policy = POL_CENTRAL;
		cur_active = ACTIVE_RESET;

		// Directed rows, from reset: central queue, all eight servers
		// completion on an idle server: load stays at zero, nothing waiting
		add_beat_row(CMD_DONE, 16'h0000, 3'd0, 1'b1, dispatch_t'{1'b0, 3'd0, 16'h0, 1'b0, 7'd0});
		add_beat_row(CMD_ARRIVAL, 16'hFFFF, 3'd7, 1'b1,
			dispatch_t'{1'b1, 3'd0, 16'hFFFF, 1'b0, 7'd0});
		add_beat_row(CMD_ARRIVAL, 16'h0000, 3'd0, 1'b1,
			dispatch_t'{1'b1, 3'd1, 16'h0000, 1'b0, 7'd0});
		add_beat_row(CMD_DONE, 16'hFFFF, 3'd7, 1'b0, '0);
		// one server: arrivals queue behind the busy one, completion releases the head
		add_cfg_row(REG_ACTIVE, 4'd1);
		add_beat_row(CMD_ARRIVAL, 16'h1234, 3'd5, 1'b1, dispatch_t'{1'b0, 3'd0, 16'h0, 1'b0, 7'd1});
		add_beat_row(CMD_ARRIVAL, 16'h5678, 3'd2, 1'b1, dispatch_t'{1'b0, 3'd0, 16'h0, 1'b0, 7'd2});
		add_beat_row(CMD_DONE, 16'h0000, 3'd0, 1'b1,
			dispatch_t'{1'b1, 3'd0, 16'h1234, 1'b0, 7'd1});
		// zero active acts as one; completion outside the range still lowers its counter
		add_cfg_row(REG_ACTIVE, 4'd0);
		add_beat_row(CMD_DONE, 16'h0000, 3'd1, 1'b0, '0);
		add_beat_row(CMD_ARRIVAL, 16'h9ABC, 3'd0, 1'b0, '0);
		// active above the built count saturates to eight
		add_cfg_row(REG_ACTIVE, 4'd15);
		add_beat_row(CMD_DONE, 16'h0000, 3'd5, 1'b0, '0);
		// shortest queue with jobs left in the wait queue
		add_cfg_row(REG_POLICY, CFG_DATA_W'(POL_SHORTEST));
		add_beat_row(CMD_ARRIVAL, 16'hAAAA, 3'd0, 1'b0, '0);
		add_beat_row(CMD_DONE, 16'h0000, 3'd2, 1'b0, '0);
		add_beat_row(CMD_ARRIVAL, 16'h5555, 3'd0, 1'b0, '0);
		add_cfg_row(REG_ACTIVE, 4'd1);
		add_beat_row(CMD_ARRIVAL, 16'h0F0F, 3'd0, 1'b0, '0);
		// back to central: leftover jobs drain again
		add_cfg_row(REG_POLICY, CFG_DATA_W'(POL_CENTRAL));
		add_cfg_row(REG_ACTIVE, 4'd8);
		add_beat_row(CMD_DONE, 16'h0000, 3'd3, 1'b0, '0);
		add_beat_row(CMD_ARRIVAL, 16'h8001, 3'd6, 1'b0, '0);
		add_beat_row(CMD_DONE, 16'hFFFF, 3'd0, 1'b0, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			else
				send_beat(directed_rows[i].cmd, directed_rows[i].job, directed_rows[i].sidx,
					directed_rows[i].typed, directed_rows[i].want);
		end

		// Random phases; a full queue with drops and a saturated load come up on their own
		for (p = 0; p < N_PHASES; p++) begin
			write_reg(REG_POLICY, {(CFG_DATA_W - 1)'($urandom_range(0, 7)), PHASE_POL[p]});
			write_reg(REG_ACTIVE, CFG_DATA_W'(PHASE_ACT[p]));
			if (p == 0)
				long_hold_req = 1'b1;
			for (k = 0; k < PHASE_LEN[p]; k++) begin
				if (p == 5 && k == PHASE_LEN[p] / 2)
					settle_results();
				n = servers_used();
				cmd = ($urandom_range(0, 99) < PHASE_ARR[p]) ? CMD_ARRIVAL : CMD_DONE;
				case ($urandom_range(0, 15))
					0: job = '0;
					1: job = '1;
					default: job = JOB_BITS'($urandom_range(0, 65535));
				endcase
				// completions mostly hit servers in use
				if ($urandom_range(0, 4) != 0)
					sidx = SIDX_BITS'($urandom_range(0, n - 1));
				else
					sidx = SIDX_BITS'($urandom_range(0, N_SERVERS - 1));
				send_beat(cmd, job, sidx, 1'b0, '0);
			end
		end

		settle_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
rtl/sdisp_pkg.sv
rtl/sdisp_min_tree.sv
rtl/server_dispatcher.sv
rtl/sdisp_checker.sv
sim/tb_server_dispatcher.sv
